[src/rmq_pkg.sv]
// Shared constants, widths and stage types for the rotation matrix to quaternion unit.
// No dependencies; imported by the unit and by its checker.
package rmq_pkg;

    // Fixed-point format of every matrix entry and quaternion component
    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int ENTRIES   = 9;
    localparam int LANES     = 4;

    // Internal widths, sized for the full 16-bit input range
    localparam int SUM_W    = IN_W + 1;
    localparam int TR_W     = IN_W + 2;
    localparam int VEC_W    = IN_W + 4;
    localparam int MAG_W    = IN_W + 2;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int N2_W     = SQ_W + 2;
    localparam int ROOT_W   = N2_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int NUM_W    = MAG_W + FRAC_BITS + 1;
    localparam int QUO_W    = FRAC_BITS + 1;
    localparam int DREM_W   = ROOT_W + 1;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = QUO_W;

    // Port widths
    localparam int S_DATA_W = ENTRIES * IN_W;
    localparam int M_DATA_W = 64;

    // Pivot choice
    typedef enum logic [3:0] {
        PIV_X = 4'b0001,
        PIV_Y = 4'b0010,
        PIV_Z = 4'b0100,
        PIV_W = 4'b1000
    } piv_t;

    // Diagonal, trace and mirrored sums and differences
    typedef struct packed {
        logic signed [IN_W-1:0]  r00;
        logic signed [IN_W-1:0]  r11;
        logic signed [IN_W-1:0]  r22;
        logic signed [TR_W-1:0]  tr;
        logic signed [SUM_W-1:0] p01;
        logic signed [SUM_W-1:0] p02;
        logic signed [SUM_W-1:0] p12;
        logic signed [SUM_W-1:0] m12;
        logic signed [SUM_W-1:0] m20;
        logic signed [SUM_W-1:0] m01;
    } mix_t;

    typedef struct packed {
        piv_t                   piv;
        logic signed [IN_W-1:0] dsel;
        mix_t                   mix;
    } pick_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] v0;
        logic signed [VEC_W-1:0] v1;
        logic signed [VEC_W-1:0] v2;
        logic signed [VEC_W-1:0] v3;
        logic                    inv;
    } vec_t;

    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [2:0]                  neg;
        logic                        inv;
    } mag_stage_t;

    typedef struct packed {
        logic [LANES-1:0][SQ_W-1:0]  sq;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [2:0]                  neg;
        logic                        inv;
    } sq_stage_t;

    typedef struct packed {
        logic [REM_W-1:0]            rem;
        logic [ROOT_W-1:0]           root;
        logic [N2_W-1:0]             n2;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [2:0]                  neg;
        logic                        inv;
    } sqrt_stage_t;

    typedef struct packed {
        logic [LANES-1:0][DREM_W-1:0] drem;
        logic [LANES-1:0][QUO_W-1:0]  qsh;
        logic [ROOT_W-1:0]            dvs;
        logic [2:0]                   neg;
        logic                         inv;
    } div_stage_t;

endpackage

[src/rotation_matrix_to_quaternion_unit.sv]
// Rotation matrix to unit quaternion converter (Shepperd's method), fully pipelined.
// Depends on rmq_pkg for widths, pivot codes and stage types.

// A request carries one 3x3 matrix in signed Q1.14; the result is the unit quaternion
// (x, y, z, w) with a non-negative scalar, in Q1.14, or all zeros with the invalid flag in
// tuser when the pivot radicand is not positive. The unit takes one request every cycle
// while not stalled and returns each result in order. The pipeline consists of the
// integer square root (one result bit per stage, 19 stages) followed by the four parallel
// divisions (one quotient bit per stage, 15 stages), plus six stages of pivot choice,
// vector forming and squaring, one division set-up stage and one output register. The
// whole pipeline advances only when the output register is empty or being taken, so
// back-pressure stalls all stages together and nothing is lost or repeated. There is no
// state between requests.
module rotation_matrix_to_quaternion_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each, lowest first)
    input  logic [rmq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[62:48], zero[63]
    output logic [rmq_pkg::M_DATA_W-1:0]  m_tdata,
    // invalid
    output logic                          m_tuser
);
    import rmq_pkg::*;

    logic adv;

    logic        a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    mix_t        a_reg, a_next;
    pick_t       b_reg, b_next;
    vec_t        c_reg, c_next;
    mag_stage_t  d_reg, d_next;
    sq_stage_t   e_reg, e_next;
    sqrt_stage_t f_reg, f_next;

    logic        sq_vld_reg [SQ_STEPS];
    sqrt_stage_t sq_reg     [SQ_STEPS];
    sqrt_stage_t sq_next    [SQ_STEPS];

    logic        dv_vld_reg [DIV_STEPS+1];
    div_stage_t  dv_reg     [DIV_STEPS+1];
    div_stage_t  dv_next    [DIV_STEPS+1];

    logic                out_vld_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_user_reg, out_user_next;

    logic signed [IN_W-1:0] in_r [ENTRIES];

    // The pipeline moves as one whenever the output register can take a new value
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            in_r[i] = s_tdata[i*IN_W +: IN_W];
        end
    end

    // Stage A: trace and mirrored off-diagonal sums and differences
    always_comb
    begin
        a_next.r00 = in_r[0];
        a_next.r11 = in_r[4];
        a_next.r22 = in_r[8];
        a_next.tr  = TR_W'(in_r[0]) + TR_W'(in_r[4]) + TR_W'(in_r[8]);
        a_next.p01 = SUM_W'(in_r[1]) + SUM_W'(in_r[3]);
        a_next.p02 = SUM_W'(in_r[2]) + SUM_W'(in_r[6]);
        a_next.p12 = SUM_W'(in_r[5]) + SUM_W'(in_r[7]);
        a_next.m12 = SUM_W'(in_r[5]) - SUM_W'(in_r[7]);
        a_next.m20 = SUM_W'(in_r[6]) - SUM_W'(in_r[2]);
        a_next.m01 = SUM_W'(in_r[1]) - SUM_W'(in_r[3]);
    end

    // Stage B: the first largest of the diagonal and the trace picks the pivot
    always_comb
    begin
        logic signed [TR_W-1:0] best;
        best        = TR_W'(a_reg.r00);
        b_next.piv  = PIV_X;
        b_next.dsel = a_reg.r00;
        b_next.mix  = a_reg;
        if (TR_W'(a_reg.r11) > best)
        begin
            best        = TR_W'(a_reg.r11);
            b_next.piv  = PIV_Y;
            b_next.dsel = a_reg.r11;
        end
        if (TR_W'(a_reg.r22) > best)
        begin
            best        = TR_W'(a_reg.r22);
            b_next.piv  = PIV_Z;
            b_next.dsel = a_reg.r22;
        end
        if (a_reg.tr > best)
        begin
            b_next.piv = PIV_W;
        end
    end

    // Stage C: radicand and the unnormalised vector
    always_comb
    begin
        logic signed [VEC_W-1:0] rad;
        if (b_reg.piv == PIV_W)
        begin
            rad = VEC_W'(ONE) + VEC_W'(b_reg.mix.tr);
        end
        else
        begin
            rad = VEC_W'(ONE) + (VEC_W'(b_reg.dsel) <<< 1) - VEC_W'(b_reg.mix.tr);
        end
        c_next.inv = (rad <= 0);
        unique case (b_reg.piv)
            PIV_X:
            begin
                c_next.v0 = rad;
                c_next.v1 = VEC_W'(b_reg.mix.p01);
                c_next.v2 = VEC_W'(b_reg.mix.p02);
                c_next.v3 = VEC_W'(b_reg.mix.m12);
            end
            PIV_Y:
            begin
                c_next.v0 = VEC_W'(b_reg.mix.p01);
                c_next.v1 = rad;
                c_next.v2 = VEC_W'(b_reg.mix.p12);
                c_next.v3 = VEC_W'(b_reg.mix.m20);
            end
            PIV_Z:
            begin
                c_next.v0 = VEC_W'(b_reg.mix.p02);
                c_next.v1 = VEC_W'(b_reg.mix.p12);
                c_next.v2 = rad;
                c_next.v3 = VEC_W'(b_reg.mix.m01);
            end
            default:
            begin
                c_next.v0 = VEC_W'(b_reg.mix.m12);
                c_next.v1 = VEC_W'(b_reg.mix.m20);
                c_next.v2 = VEC_W'(b_reg.mix.m01);
                c_next.v3 = rad;
            end
        endcase
    end

    // Stage D: magnitudes and signs, with the scalar forced non-negative
    always_comb
    begin
        logic signed [VEC_W-1:0] v [LANES];
        logic                    wneg;
        v[0] = c_reg.v0;
        v[1] = c_reg.v1;
        v[2] = c_reg.v2;
        v[3] = c_reg.v3;
        wneg = c_reg.v3[VEC_W-1];
        for (int j = 0; j < LANES; j++)
        begin
            d_next.mag[j] = MAG_W'(v[j][VEC_W-1] ? -v[j] : v[j]);
        end
        for (int j = 0; j < 3; j++)
        begin
            d_next.neg[j] = v[j][VEC_W-1] ^ wneg;
        end
        d_next.inv = c_reg.inv;
    end

    // Stage E: squares of the four magnitudes
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            e_next.sq[j] = SQ_W'(d_reg.mag[j]) * SQ_W'(d_reg.mag[j]);
        end
        e_next.mag = d_reg.mag;
        e_next.neg = d_reg.neg;
        e_next.inv = d_reg.inv;
    end

    // Stage F: squared norm, ready for the root
    always_comb
    begin
        f_next.rem  = '0;
        f_next.root = '0;
        f_next.n2   = (N2_W'(e_reg.sq[0]) + N2_W'(e_reg.sq[1]))
                    + (N2_W'(e_reg.sq[2]) + N2_W'(e_reg.sq[3]));
        f_next.mag  = e_reg.mag;
        f_next.neg  = e_reg.neg;
        f_next.inv  = e_reg.inv;
    end

    // Integer square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        sqrt_stage_t      prv;
        logic [REM_W-1:0] rin;
        logic [REM_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign prv = f_reg;
        end
        else
        begin : g_rest
            assign prv = sq_reg[k-1];
        end

        assign rin   = {prv.rem[REM_W-3:0], prv.n2[N2_W-1-2*k -: 2]};
        assign trial = REM_W'({prv.root, 2'b01});

        always_comb
        begin
            sq_next[k] = prv;
            if (rin >= trial)
            begin
                sq_next[k].rem  = rin - trial;
                sq_next[k].root = {prv.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = rin;
                sq_next[k].root = {prv.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Division set-up: rounded numerators, top part as the first partial remainder
    always_comb
    begin
        logic [ROOT_W-1:0] s;
        logic [NUM_W-1:0]  num;
        s = sq_reg[SQ_STEPS-1].root;
        dv_next[0].dvs = s;
        dv_next[0].neg = sq_reg[SQ_STEPS-1].neg;
        dv_next[0].inv = sq_reg[SQ_STEPS-1].inv;
        for (int j = 0; j < LANES; j++)
        begin
            num = {1'b0, sq_reg[SQ_STEPS-1].mag[j], {FRAC_BITS{1'b0}}}
                + NUM_W'(s >> 1);
            dv_next[0].drem[j] = DREM_W'(num[NUM_W-1:QUO_W]);
            dv_next[0].qsh[j]  = num[QUO_W-1:0];
        end
    end

    // Restoring division, one quotient bit per stage in all four lanes
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        always_comb
        begin
            logic [DREM_W-1:0] r2;
            logic              qb;
            dv_next[k] = dv_reg[k-1];
            for (int j = 0; j < LANES; j++)
            begin
                r2 = {dv_reg[k-1].drem[j][DREM_W-2:0], dv_reg[k-1].qsh[j][QUO_W-1]};
                qb = (r2 >= DREM_W'(dv_reg[k-1].dvs));
                dv_next[k].drem[j] = qb ? r2 - DREM_W'(dv_reg[k-1].dvs) : r2;
                dv_next[k].qsh[j]  = {dv_reg[k-1].qsh[j][QUO_W-2:0], qb};
            end
        end
    end

    // Output: apply signs, zero the result when the radicand was not positive
    always_comb
    begin
        logic [IN_W-1:0] comp [3];
        for (int j = 0; j < 3; j++)
        begin
            comp[j] = dv_reg[DIV_STEPS].neg[j] ? -IN_W'(dv_reg[DIV_STEPS].qsh[j])
                                               : IN_W'(dv_reg[DIV_STEPS].qsh[j]);
        end
        if (dv_reg[DIV_STEPS].inv)
        begin
            out_data_next = '0;
        end
        else
        begin
            out_data_next = {1'b0, dv_reg[DIV_STEPS].qsh[3], comp[2], comp[1], comp[0]};
        end
        out_user_next = dv_reg[DIV_STEPS].inv;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_vld_reg     <= s_tvalid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= d_vld_reg;
            f_vld_reg     <= e_vld_reg;
            sq_vld_reg[0] <= f_vld_reg;
            for (int k = 1; k < SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS-1];
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            out_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
            f_reg <= f_next;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule

[src/rmq_checker.sv]
// Port-level checks for the rotation matrix to quaternion unit, bound to its top level.
// Depends on rmq_pkg for port widths.
module rmq_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rmq_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rmq_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tuser
);
    import rmq_pkg::*;

    // A stalled result holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Requests are taken whenever the output register is free or draining
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output space");

    // An invalid result carries an all-zero quaternion
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("invalid result with non-zero quaternion");

    // Every component of a valid result lies within one in magnitude
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            $signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384
         && $signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384
         && $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384
         && m_tdata[62:48] <= 15'd16384 && !m_tdata[63])
        else $error("quaternion component out of range");

    // No result appears straight out of reset
    a_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);
